>>> rtl/cts_pkg.sv
// Shared types, constants and character helpers for the C-like token scanner.
package cts_pkg;

   // Scanner modes between bytes
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BSTAR,
      MODE_STR,
      MODE_ESC,
      MODE_IDENT,
      MODE_NUM
   } scan_mode_type;

   // Token kind codes
   localparam logic [4:0] KIND_SEMI    = 5'd0;
   localparam logic [4:0] KIND_COLON   = 5'd1;
   localparam logic [4:0] KIND_STAR    = 5'd2;
   localparam logic [4:0] KIND_LPAREN  = 5'd3;
   localparam logic [4:0] KIND_RPAREN  = 5'd4;
   localparam logic [4:0] KIND_LBRACK  = 5'd5;
   localparam logic [4:0] KIND_RBRACK  = 5'd6;
   localparam logic [4:0] KIND_LBRACE  = 5'd7;
   localparam logic [4:0] KIND_RBRACE  = 5'd8;
   localparam logic [4:0] KIND_ASSIGN  = 5'd9;
   localparam logic [4:0] KIND_END     = 5'd10;
   localparam logic [4:0] KIND_UNDER   = 5'd11;
   localparam logic [4:0] KIND_STRING  = 5'd12;
   localparam logic [4:0] KIND_BOOL    = 5'd13;
   localparam logic [4:0] KIND_IDENT   = 5'd14;
   localparam logic [4:0] KIND_FLOAT   = 5'd15;
   localparam logic [4:0] KIND_INT     = 5'd16;
   localparam logic [4:0] KIND_UNKNOWN = 5'd17;

   // Characters with a special role
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // Keyword tracker codes: positions within "true" and "false"
   localparam logic [3:0] KW_NONE  = 4'd0;
   localparam logic [3:0] KW_T     = 4'd1;
   localparam logic [3:0] KW_TRUE  = 4'd4;
   localparam logic [3:0] KW_F     = 4'd5;
   localparam logic [3:0] KW_FALSE = 4'd9;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   // One token record as delivered on the result channel
   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
   } token_rec_type;

   // All records caused by one source byte, first record in slot 0
   typedef struct packed {
      token_rec_type [2:0] rec;
      logic [1:0]          count;
   } token_bundle_type;

   // Scanner state apart from the offset counters
   typedef struct packed {
      scan_mode_type mode;
      logic [15:0]   len;
      logic [3:0]    kw;
      logic          float_seen;
      logic          prev_digit;
   } scan_state_type;

   localparam scan_state_type STATE_RESET = '{
      mode: MODE_IDLE, len: 16'd0, kw: KW_NONE, float_seen: 1'b0, prev_digit: 1'b0
   };

   // Expected next character for each keyword tracker position
   function automatic logic [7:0] kw_next(input logic [3:0] idx);
      case (idx)
         4'd1:    kw_next = 8'h72; // r
         4'd2:    kw_next = 8'h75; // u
         4'd3:    kw_next = 8'h65; // e
         4'd5:    kw_next = 8'h61; // a
         4'd6:    kw_next = 8'h6C; // l
         4'd7:    kw_next = 8'h73; // s
         4'd8:    kw_next = 8'h65; // e
         default: kw_next = 8'h00;
      endcase
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c inside {[8'h30:8'h39]});
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C});
   endfunction

   // Saturating length increment
   function automatic logic [15:0] len_inc(input logic [15:0] len);
      len_inc = (len == LEN_MAX) ? len : len + 16'd1;
   endfunction

endpackage

>>> rtl/cts_if.sv
// Valid/ready channel interfaces for source bytes and token records.
interface cts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface cts_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        run_last;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output run_last, input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_length, input run_last, output ready);
endinterface

>>> rtl/c_like_token_scanner.sv
// Top level of the C-like token scanner: input register, scanner state and result buffer.
//
// Source text enters on req_bus, one byte per word, with final_byte set on the
// last byte of a text. Token records (kind, start offset, length) leave on
// rsp_bus; run_last marks the last record caused by one byte, and a byte may
// cause none, one, two or three records.
// A byte is taken into an input register; once the result register is free the
// scanner works on it and loads its records into the result register, from
// which the first record is presented on rsp_bus.
// Throughput is one byte per cycle while each byte yields at most one record
// and rsp_bus does not stall; a byte that yields several records holds the result
// register until all have left, since the result channel carries one record per cycle.
// When rsp_bus stalls, one further byte is still accepted into the input
// register; req_bus.ready then drops until the result register drains.
// Reset (synchronous) puts the scanner between tokens with offset zero and
// empties both registers. After a final byte the scanner returns to that
// same state, so the next text counts offsets from zero.
// Offsets wrap at 2^POS_BITS and are reported in 16 bits; lengths saturate.
module c_like_token_scanner
   import cts_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   cts_req_if.sink   req_bus,
   cts_rsp_if.source rsp_bus
);

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_final_ff;
   logic                buf_free;
   logic                advance;
   logic                req_take;

   scan_state_type      st_ff;
   scan_state_type      st_in;
   logic [POS_BITS-1:0] start_ff;
   logic [POS_BITS-1:0] start_in;
   logic [POS_BITS-1:0] pos_ff;
   logic [POS_BITS-1:0] pos_in;
   token_bundle_type    bundle;

   assign advance       = in_valid_ff && buf_free;
   assign req_bus.ready = !in_valid_ff || buf_free;
   assign req_take      = req_bus.valid && req_bus.ready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_bus.text_byte;
         in_final_ff <= req_bus.final_byte;
      end
   end

   cts_step #(
      .POS_BITS (POS_BITS)
   ) u_step (
      .text_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .state_i    (st_ff),
      .start_i    (start_ff),
      .pos_i      (pos_ff),
      .state_o    (st_in),
      .start_o    (start_in),
      .pos_o      (pos_in),
      .bundle_o   (bundle)
   );

   // Scanner state advances as each byte moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= STATE_RESET;
         start_ff <= '0;
         pos_ff   <= '0;
      end else if (advance) begin
         st_ff    <= st_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
      end
   end

   cts_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .bundle_i (bundle),
      .free     (buf_free),
      .rsp      (rsp_bus)
   );

   // A held byte stays in the input register until the result register frees
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !buf_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held source byte lost or changed");

   // A final byte always produces at least the end record
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      advance && in_final_ff |=> rsp_bus.valid)
      else $error("final byte produced no record");

   // A final byte puts the scanner back between tokens at offset zero
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      advance && in_final_ff |=> st_ff.mode == MODE_IDLE && pos_ff == '0)
      else $error("scanner state not restored after final byte");

   // The input register only loads when it is empty or emptying
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_take && in_valid_ff |-> advance)
      else $error("input register overwritten");

endmodule

>>> rtl/cts_step.sv
// Combinational scan of one source byte: next state and the token records it causes.
module cts_step
   import cts_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic [7:0]          text_byte,
   input  logic                final_byte,
   input  scan_state_type      state_i,
   input  logic [POS_BITS-1:0] start_i,
   input  logic [POS_BITS-1:0] pos_i,
   output scan_state_type      state_o,
   output logic [POS_BITS-1:0] start_o,
   output logic [POS_BITS-1:0] pos_o,
   output token_bundle_type    bundle_o
);

   scan_state_type      s1;
   logic [POS_BITS-1:0] st1;
   logic [POS_BITS-1:0] pos_next;
   logic                do_start;
   token_rec_type [3:0] cand;
   logic [3:0]          cand_v;
   logic [2:0]          n;

   assign pos_next = pos_i + POS_BITS'(1);

   // Mode update, token start and closing of unterminated tokens at the final byte
   always_comb begin
      s1       = state_i;
      st1      = start_i;
      do_start = 1'b0;
      cand     = '0;
      cand_v   = '0;

      // Continue or close the token in progress
      case (state_i.mode)
         MODE_SLASH: begin
            if (text_byte == CH_SLASH) begin
               s1.mode = MODE_LINE;
            end else if (text_byte == CH_STAR) begin
               s1.mode = MODE_BLOCK;
            end else begin
               cand_v[0] = 1'b1;
               cand[0]   = '{kind: KIND_UNKNOWN, start: 16'(start_i), length: 16'd1};
               do_start  = 1'b1;
            end
         end
         MODE_LINE: begin
            if (text_byte == CH_LF || text_byte == CH_CR) begin
               s1.mode = MODE_IDLE;
            end
         end
         MODE_BLOCK: begin
            if (text_byte == CH_STAR) begin
               s1.mode = MODE_BSTAR;
            end
         end
         MODE_BSTAR: begin
            if (text_byte == CH_SLASH) begin
               s1.mode = MODE_IDLE;
            end else if (text_byte != CH_STAR) begin
               s1.mode = MODE_BLOCK;
            end
         end
         MODE_STR: begin
            if (text_byte == CH_QUOTE) begin
               cand_v[0] = 1'b1;
               cand[0]   = '{kind: KIND_STRING, start: 16'(start_i), length: state_i.len};
               s1.mode   = MODE_IDLE;
            end else begin
               s1.len = len_inc(state_i.len);
               if (text_byte == CH_BSLASH) begin
                  s1.mode = MODE_ESC;
               end
            end
         end
         MODE_ESC: begin
            s1.len  = len_inc(state_i.len);
            s1.mode = MODE_STR;
         end
         MODE_IDENT: begin
            if (is_alpha(text_byte) || is_digit(text_byte) ||
                text_byte == CH_UNDER || text_byte == CH_COLON) begin
               s1.len = len_inc(state_i.len);
               if (state_i.kw != KW_NONE && state_i.kw != KW_TRUE &&
                   state_i.kw != KW_FALSE && kw_next(state_i.kw) == text_byte) begin
                  s1.kw = state_i.kw + 4'd1;
               end else begin
                  s1.kw = KW_NONE;
               end
            end else begin
               cand_v[0] = 1'b1;
               cand[0]   = '{kind: (state_i.kw == KW_TRUE || state_i.kw == KW_FALSE) ?
                                   KIND_BOOL : KIND_IDENT,
                             start: 16'(start_i), length: state_i.len};
               do_start  = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_digit(text_byte)) begin
               s1.len        = len_inc(state_i.len);
               s1.prev_digit = 1'b1;
            end else if (state_i.prev_digit &&
                         (text_byte == CH_DOT || text_byte == CH_LOW_F)) begin
               s1.len        = len_inc(state_i.len);
               s1.float_seen = 1'b1;
               s1.prev_digit = 1'b0;
            end else begin
               cand_v[0] = 1'b1;
               cand[0]   = '{kind: state_i.float_seen ? KIND_FLOAT : KIND_INT,
                             start: 16'(start_i), length: state_i.len};
               do_start  = 1'b1;
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase

      // Scan the byte as the first character of a new token
      if (do_start) begin
         s1.mode = MODE_IDLE;
         if (is_space(text_byte)) begin
            s1.mode = MODE_IDLE;
         end else if (text_byte inside {CH_SEMI, CH_COLON, CH_STAR, 8'h28, 8'h29, 8'h5B,
                                        8'h5D, 8'h7B, 8'h7D, CH_EQUAL, CH_NUL, CH_UNDER}) begin
            cand_v[1] = 1'b1;
            cand[1].start  = 16'(pos_i);
            cand[1].length = 16'd1;
            case (text_byte)
               CH_SEMI:  cand[1].kind = KIND_SEMI;
               CH_COLON: cand[1].kind = KIND_COLON;
               CH_STAR:  cand[1].kind = KIND_STAR;
               8'h28:    cand[1].kind = KIND_LPAREN;
               8'h29:    cand[1].kind = KIND_RPAREN;
               8'h5B:    cand[1].kind = KIND_LBRACK;
               8'h5D:    cand[1].kind = KIND_RBRACK;
               8'h7B:    cand[1].kind = KIND_LBRACE;
               8'h7D:    cand[1].kind = KIND_RBRACE;
               CH_EQUAL: cand[1].kind = KIND_ASSIGN;
               CH_NUL:   cand[1].kind = KIND_END;
               default:  cand[1].kind = KIND_UNDER;
            endcase
         end else if (text_byte == CH_SLASH) begin
            s1.mode = MODE_SLASH;
            st1     = pos_i;
         end else if (text_byte == CH_QUOTE) begin
            s1.mode = MODE_STR;
            st1     = pos_next;
            s1.len  = 16'd0;
         end else if (is_alpha(text_byte)) begin
            s1.mode = MODE_IDENT;
            st1     = pos_i;
            s1.len  = 16'd1;
            s1.kw   = (text_byte == CH_LOW_T) ? KW_T :
                      (text_byte == CH_LOW_F) ? KW_F : KW_NONE;
         end else if (is_digit(text_byte)) begin
            s1.mode       = MODE_NUM;
            st1           = pos_i;
            s1.len        = 16'd1;
            s1.float_seen = 1'b0;
            s1.prev_digit = 1'b1;
         end else begin
            cand_v[1] = 1'b1;
            cand[1]   = '{kind: KIND_UNKNOWN, start: 16'(pos_i), length: 16'd1};
         end
      end

      // At the final byte close any token that is open, then add the end token
      if (final_byte) begin
         case (s1.mode)
            MODE_IDENT: begin
               cand_v[2] = 1'b1;
               cand[2]   = '{kind: (s1.kw == KW_TRUE || s1.kw == KW_FALSE) ?
                                   KIND_BOOL : KIND_IDENT,
                             start: 16'(st1), length: s1.len};
            end
            MODE_NUM: begin
               cand_v[2] = 1'b1;
               cand[2]   = '{kind: s1.float_seen ? KIND_FLOAT : KIND_INT,
                             start: 16'(st1), length: s1.len};
            end
            MODE_STR, MODE_ESC: begin
               cand_v[2] = 1'b1;
               cand[2]   = '{kind: KIND_STRING, start: 16'(st1), length: s1.len};
            end
            MODE_SLASH: begin
               cand_v[2] = 1'b1;
               cand[2]   = '{kind: KIND_UNKNOWN, start: 16'(st1), length: 16'd1};
            end
            default: begin
               cand_v[2] = 1'b0;
            end
         endcase
         cand_v[3] = 1'b1;
         cand[3]   = '{kind: KIND_END, start: 16'(pos_next), length: 16'd1};
      end
   end

   // Next state: a final byte returns everything to its reset values
   always_comb begin
      if (final_byte) begin
         state_o = STATE_RESET;
         start_o = '0;
         pos_o   = '0;
      end else begin
         state_o = s1;
         start_o = st1;
         pos_o   = pos_next;
      end
   end

   // Pack the records in order into the bundle; at most three are ever present
   always_comb begin
      bundle_o = '0;
      n        = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i] && n != 3'd3) begin
            bundle_o.rec[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      bundle_o.count = n[1:0];
   end

endmodule

>>> rtl/cts_out_buf.sv
// Result register holding the records of one byte and handing them out one word at a time.
module cts_out_buf
   import cts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  token_bundle_type bundle_i,
   output logic             free,
   cts_rsp_if.source        rsp
);

   token_bundle_type bundle_ff;
   logic [1:0]       total_ff;
   logic [1:0]       total_in;
   logic [1:0]       idx_ff;
   logic [1:0]       idx_in;
   logic             pop;
   token_rec_type    cur;

   assign rsp.valid = (idx_ff != total_ff);
   assign pop       = rsp.valid && rsp.ready;
   // Free for a new bundle when nothing is pending or the last pending word leaves this cycle
   assign free      = !rsp.valid || (pop && (idx_ff + 2'd1 == total_ff));

   assign cur              = bundle_ff.rec[idx_ff];
   assign rsp.token_kind   = cur.kind;
   assign rsp.token_start  = cur.start;
   assign rsp.token_length = cur.length;
   assign rsp.run_last     = (idx_ff + 2'd1 == total_ff);

   // Read pointer and record count
   always_comb begin
      total_in = total_ff;
      idx_in   = idx_ff;
      if (load) begin
         total_in = bundle_i.count;
         idx_in   = 2'd0;
      end else if (pop) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         total_ff <= total_in;
         idx_ff   <= idx_in;
      end
   end

   // Record payload
   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle_i;
      end
   end

endmodule
